FILE: rtl/cas_pkg.sv
// Shared types and constants for the contrast-adaptive sharpener.
package cas_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] RegWidth = 2'd0;
  localparam logic [CfgIdxW-1:0] RegHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] RegSharp = 2'd2;

  // Job handed from the window front to the arithmetic back.
  typedef struct packed {
    logic [8:0][7:0] wn;
    logic            use_center;
    logic [9:0]      row;
    logic [9:0]      col;
    logic            last;
    logic            done;
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_DIV, BK_SQRT, BK_MUL, BK_QDIV, BK_OUT
  } bk_state_t;

endpackage

FILE: rtl/cas_if.sv
// Valid/ready channel interfaces.
interface cas_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_in;
  modport source (output valid, output pixel_in, input ready);
  modport sink (input valid, input pixel_in, output ready);
endinterface

interface cas_res_if;
  logic       valid;
  logic       ready;
  logic [9:0] out_row;
  logic [9:0] out_col;
  logic [7:0] out_value;
  logic       last_of_run;
  logic       frame_done;
  modport source (output valid, output out_row, output out_col, output out_value,
                  output last_of_run, output frame_done, input ready);
  modport sink (input valid, input out_row, input out_col, input out_value,
                input last_of_run, input frame_done, output ready);
endinterface

interface cas_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [10:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/cas_front.sv
// Line stores, 3x3 window and result scheduling.
module cas_front #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          pixel,
  input  logic [13:0]         wd,
  input  logic [13:0]         ht,
  input  logic                restart,
  output logic                job_valid,
  input  logic                job_ready,
  output cas_pkg::job_t       job
);
  import cas_pkg::*;

  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic [7:0]      older_line [MAX_WIDTH];
  logic [7:0]      newer_line [MAX_WIDTH];
  logic [13:0]     row_count, col_count;
  logic [8:0][7:0] win;

  // stage 1: memory read of the accepted pixel's column
  logic        s1_valid;
  logic [7:0]  s1_px;
  logic [13:0] s1_r, s1_c;
  logic [7:0]  rd_old, rd_new;

  // emitted words for the current pixel (up to three), sent one per cycle while the queue accepts them
  job_t        pend [3];
  logic [1:0]  pend_n, pend_i;
  logic        busy;

  logic [13:0] r0, c0;
  logic        acc;
  assign r0 = (row_count >= ht) ? 14'd0 : row_count;
  assign c0 = (col_count >= wd) ? 14'd0 : col_count;
  assign in_ready = !s1_valid && !busy;
  assign acc = in_valid && in_ready;

  // read on accept, write back in stage 1 from the registered read data
  always_ff @(posedge clk) begin
    if (acc) begin
      rd_old <= older_line[c0[AW-1:0]];
      rd_new <= newer_line[c0[AW-1:0]];
    end
    if (s1_valid) begin
      older_line[s1_c[AW-1:0]] <= rd_new;
      newer_line[s1_c[AW-1:0]] <= s1_px;
    end
  end

  logic [8:0][7:0] w_n;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      w_n[3*i]   = win[3*i+1];
      w_n[3*i+1] = win[3*i+2];
    end
    w_n[2] = rd_old;
    w_n[5] = rd_new;
    w_n[8] = s1_px;
  end

  job_t       e [3];
  logic [1:0] n;
  logic       last_row;
  always_comb begin
    last_row = (s1_r == ht - 14'd1);
    for (int i = 0; i < 3; i++) begin
      e[i] = '0;
      e[i].wn = w_n;
    end
    n = 2'd0;
    if (s1_r >= 14'd1) begin
      if (s1_c >= 14'd1) begin
        e[0].row = 10'(s1_r - 14'd1);
        e[0].col = 10'(s1_c - 14'd1);
        e[0].use_center = (s1_r == 14'd1) || (s1_c == 14'd1) || (s1_c == wd);
        n = 2'd1;
      end
      if (s1_c == wd - 14'd1) begin
        e[n].row = 10'(s1_r - 14'd1);
        e[n].col = 10'(s1_c);
        e[n].use_center = 1'b1;
        e[n].wn[4] = w_n[5];
        n = n + 2'd1;
      end
    end
    if (last_row) begin
      e[n].row = 10'(s1_r);
      e[n].col = 10'(s1_c);
      e[n].use_center = 1'b1;
      e[n].wn[4] = s1_px;
      e[n].done = (s1_c == wd - 14'd1);
      n = n + 2'd1;
    end
    if (n != 2'd0) e[n-2'd1].last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
      s1_valid <= 1'b0;
      busy <= 1'b0;
      pend_n <= '0;
      pend_i <= '0;
      win <= '0;
    end else begin
      if (acc) begin
        s1_px <= pixel;
        s1_r <= r0;
        s1_c <= c0;
      end
      if (restart) begin
        row_count <= '0;
        col_count <= '0;
      end else if (acc) begin
        if (c0 + 14'd1 >= wd) begin
          col_count <= '0;
          row_count <= (r0 + 14'd1 >= ht) ? 14'd0 : r0 + 14'd1;
        end else begin
          col_count <= c0 + 14'd1;
          row_count <= r0;
        end
      end
      s1_valid <= acc;
      if (s1_valid) begin
        win <= w_n;
        pend <= e;
        pend_n <= n;
        pend_i <= '0;
        busy <= (n != 2'd0);
      end else if (busy && job_ready) begin
        pend_i <= pend_i + 2'd1;
        if (pend_i + 2'd1 == pend_n) busy <= 1'b0;
      end
    end
  end

  assign job_valid = busy;
  assign job = pend[pend_i];
endmodule

FILE: rtl/cas_queue.sv
// Short FIFO between window front and arithmetic back.
module cas_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  cas_pkg::job_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output cas_pkg::job_t rd_data
);
  import cas_pkg::*;

  job_t       mem [4];
  logic [1:0] wp, rp;
  logic [2:0] cnt;
  logic       wr, rd;

  assign wr_ready = (cnt != 3'd4);
  assign rd_valid = (cnt != 3'd0);
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;
  assign rd_data = mem[rp];

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wr_data;
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (wr) wp <= wp + 2'd1;
      if (rd) rp <= rp + 2'd1;
      cnt <= cnt + 3'(wr) - 3'(rd);
    end
  end
endmodule

FILE: rtl/cas_back.sv
// Sharpening arithmetic: serial divide, serial root, serial quotient.
module cas_back (
  input  logic          clk,
  input  logic          rst,
  input  logic [8:0]    sharp,
  input  logic          job_valid,
  output logic          job_ready,
  input  cas_pkg::job_t job,
  output logic          res_valid,
  input  logic          res_ready,
  output logic [9:0]    res_row,
  output logic [9:0]    res_col,
  output logic [7:0]    res_value,
  output logic          res_last,
  output logic          res_done
);
  import cas_pkg::*;

  bk_state_t st, st_next;
  job_t      jb;
  logic [5:0] step;

  function automatic logic [7:0] mn2(input logic [7:0] a, input logic [7:0] b);
    return (a < b) ? a : b;
  endfunction
  function automatic logic [7:0] mx2(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? a : b;
  endfunction

  logic [7:0] cn, cx, dn, dx;
  logic [8:0] mn, mx, num;
  always_comb begin
    cn = mn2(mn2(mn2(jb.wn[1], jb.wn[3]), mn2(jb.wn[4], jb.wn[5])), jb.wn[7]);
    cx = mx2(mx2(mx2(jb.wn[1], jb.wn[3]), mx2(jb.wn[4], jb.wn[5])), jb.wn[7]);
    dn = mn2(mn2(jb.wn[0], jb.wn[2]), mn2(jb.wn[6], jb.wn[8]));
    dx = mx2(mx2(jb.wn[0], jb.wn[2]), mx2(jb.wn[6], jb.wn[8]));
    mn = {1'b0, cn} + {1'b0, mn2(cn, dn)};
    mx = {1'b0, cx} + {1'b0, mx2(cx, dx)};
    num = (mn < 9'd510 - mx) ? mn : 9'd510 - mx;
  end

  // num <= mx, so bit 32 of the ratio is (num == mx); 32 restoring steps
  // give the rest. Bits [33:32] then feed the root two at a time.
  logic [33:0] ratio;
  logic [8:0]  drem;
  logic [9:0]  d2;
  logic        dge;
  // floor square root, one result bit per cycle
  logic [17:0] sv;
  logic [16:0] sres;
  logic [19:0] v2, trl;
  // products and final quotient
  logic [8:0]  sh;
  logic [11:0] k;
  logic [9:0]  s4;
  logic [27:0] p_kc, p_as;
  logic signed [29:0] top, top_r;
  logic [19:0] bot, bot_r;
  logic        top_le0, sat;
  logic [27:0] qrem, qdv;
  logic [7:0]  qv;
  logic        qge;
  logic [7:0]  val;

  always_comb begin
    d2 = {drem, 1'b0};
    dge = (d2 >= {1'b0, mx});
    v2 = {sv, ratio[33:32]};
    trl = {1'b0, sres, 2'b01};
    sh = (sharp > 9'd256) ? 9'd256 : sharp;
    k = 12'd2048 - ({2'b0, sh, 1'b0} + {3'b0, sh});
    s4 = {2'b0, jb.wn[1]} + {2'b0, jb.wn[3]} + {2'b0, jb.wn[5]} + {2'b0, jb.wn[7]};
    p_kc = 28'({k, 8'd0}) * 28'(jb.wn[4]);
    p_as = 28'(sres) * 28'(s4);
    top = $signed({2'b0, p_kc}) - $signed({2'b0, p_as});
    bot = {k, 8'd0} - {1'b0, sres, 2'b00};
    top_le0 = top_r[29] || (top_r == '0);
    // quotient would reach 256 or more
    sat = (top_r[27:0] >= {bot_r, 8'd0});
    qge = (qrem >= qdv);
  end

  always_ff @(posedge clk) begin
    if (rst) st <= BK_IDLE;
    else st <= st_next;
  end

  always_comb begin
    st_next = st;
    unique case (st)
      BK_IDLE: if (job_valid) st_next = BK_DIV;
      BK_DIV: begin
        if (step == 6'd0) begin
          if (jb.use_center || mx == 9'd0) st_next = BK_OUT;
        end else if (step == 6'd32) begin
          st_next = BK_SQRT;
        end
      end
      BK_SQRT: if (step == 6'd16) st_next = BK_MUL;
      BK_MUL:  st_next = BK_QDIV;
      BK_QDIV: begin
        if (step == 6'd0) begin
          if (top_le0 || sat) st_next = BK_OUT;
        end else if (step == 6'd8) begin
          st_next = BK_OUT;
        end
      end
      BK_OUT:  if (res_ready) st_next = BK_IDLE;
      default: st_next = BK_IDLE;
    endcase
  end

  assign job_ready = (st == BK_IDLE);
  assign res_valid = (st == BK_OUT);
  assign res_row = jb.row;
  assign res_col = jb.col;
  assign res_last = jb.last;
  assign res_done = jb.done;
  assign res_value = val;

  always_ff @(posedge clk) begin
    unique case (st)
      BK_IDLE: begin
        jb <= job;
        step <= '0;
      end
      BK_DIV: begin
        if (step == 6'd0) begin
          val <= jb.wn[4];
          if (num == mx) begin
            drem <= '0;
            ratio <= {2'b01, 32'd0};
          end else begin
            drem <= num;
            ratio <= '0;
          end
          step <= 6'd1;
        end else begin
          if (dge) drem <= 9'(d2 - {1'b0, mx});
          else drem <= d2[8:0];
          ratio[31:0] <= {ratio[30:0], dge};
          if (step == 6'd32) begin
            step <= '0;
            sv <= '0;
            sres <= '0;
          end else begin
            step <= step + 6'd1;
          end
        end
      end
      BK_SQRT: begin
        if (v2 >= trl) begin
          sv <= 18'(v2 - trl);
          sres <= {sres[15:0], 1'b1};
        end else begin
          sv <= 18'(v2);
          sres <= {sres[15:0], 1'b0};
        end
        ratio <= {ratio[31:0], 2'b00};
        step <= step + 6'd1;
      end
      BK_MUL: begin
        top_r <= top;
        bot_r <= bot;
        step <= '0;
      end
      BK_QDIV: begin
        if (step == 6'd0) begin
          if (top_le0) val <= '0;
          else if (sat) val <= 8'd255;
          qrem <= top_r[27:0];
          qdv <= {1'b0, bot_r, 7'd0};
          qv <= '0;
          step <= 6'd1;
        end else begin
          if (qge) qrem <= qrem - qdv;
          qv <= {qv[6:0], qge};
          qdv <= {1'b0, qdv[27:1]};
          if (step == 6'd8) val <= {qv[6:0], qge};
          step <= step + 6'd1;
        end
      end
      default: ;
    endcase
  end
endmodule

FILE: rtl/contrast_adaptive_sharpen.sv
// Top level: contrast-adaptive sharpener for raster grey pixels.
// Usage:
//   pix (sink): one 8-bit grey pixel per word, raster order.
//   res (source): out_row, out_col, out_value, last_of_run, frame_done.
//   cfg (sink): index 0 frame_width, 1 frame_height, 2 sharpness;
//   width/height writes restart the frame; write only while idle.
// Each pixel gives zero to three result words; the front takes a new
// pixel only once it has handed on every result word of the last one.
// Border words and all-zero windows skip the arithmetic in the back;
// sharpened interior words go through a bit-serial divider, square
// root, product and quotient, which stops early on a zero or full result.
// A 4-entry queue between front and back lets the front keep filling
// while the back works or the receiver stalls on res.
// Reset clears counters, window and queue; line stores need no clearing.
module contrast_adaptive_sharpen #(
  parameter int unsigned MAX_WIDTH = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input logic       clk,
  input logic       rst,
  cas_pix_if.sink   pix,
  cas_res_if.source res,
  cas_cfg_if.sink   cfg
);
  import cas_pkg::*;

  logic [10:0] frame_width, frame_height;
  logic [8:0]  sharpness;
  logic [13:0] wd, ht;
  logic        restart;

  assign cfg.ready = 1'b1;
  assign restart = cfg.valid && (cfg.index == RegWidth || cfg.index == RegHeight);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= 11'd1024;
      frame_height <= 11'd1024;
      sharpness <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        RegWidth:  frame_width <= cfg.data;
        RegHeight: frame_height <= cfg.data;
        RegSharp:  sharpness <= cfg.data[8:0];
        default: ;
      endcase
    end
  end

  assign wd = (frame_width == 11'd0) ? 14'd1 :
              (14'(frame_width) > 14'(MAX_WIDTH)) ? 14'(MAX_WIDTH) : 14'(frame_width);
  assign ht = (frame_height == 11'd0) ? 14'd1 :
              (14'(frame_height) > 14'(MAX_HEIGHT)) ? 14'(MAX_HEIGHT) : 14'(frame_height);

  logic  fj_valid, fj_ready, bj_valid, bj_ready;
  job_t  fj, bj;

  cas_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk, .rst, .in_valid(pix.valid), .in_ready(pix.ready), .pixel(pix.pixel_in),
    .wd, .ht, .restart, .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
  );

  cas_queue u_queue (
    .clk, .rst, .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_data(fj),
    .rd_valid(bj_valid), .rd_ready(bj_ready), .rd_data(bj)
  );

  cas_back u_back (
    .clk, .rst, .sharp(sharpness), .job_valid(bj_valid), .job_ready(bj_ready),
    .job(bj), .res_valid(res.valid), .res_ready(res.ready), .res_row(res.out_row),
    .res_col(res.out_col), .res_value(res.out_value), .res_last(res.last_of_run),
    .res_done(res.frame_done)
  );
endmodule
